// ===== rtl/core/ptx_pkg.sv =====
// ptx_pkg: shared types and constants for the 4x4 point transform
// no dependencies; imported by ptx_dot, ptx_div_step, point_transform_4x4 and the testbench
package ptx_pkg;

    // coefficient format and register file layout
    localparam int COEF_W     = 32;
    localparam int NUM_PAIRS  = 8;
    localparam int PAIR_IDX_W = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 2 * COEF_W;

    // register indexes that reset away from zero
    localparam int REG_M00_M01 = 0;
    localparam int REG_M10_M11 = 2;
    localparam int REG_M22_M23 = 5;
    localparam int REG_M32_M33 = 7;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [CFG_DATA_W-1:0]    cfg_word_t;

endpackage

// ===== rtl/core/ptx_dot.sv =====
// ptx_dot: one matrix column, x*m0 + y*m1 + z*m2 + 1.0*m3, three register stages
// depends on ptx_pkg
module ptx_dot
    import ptx_pkg::*;
#(
    parameter int CW = 32,
    parameter int FB = 16,
    parameter int SW = 66
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x,
    input  logic signed [CW-1:0] y,
    input  logic signed [CW-1:0] z,
    input  coef_t                m0,
    input  coef_t                m1,
    input  coef_t                m2,
    input  coef_t                m3,
    output logic signed [SW-1:0] sum
);

    localparam int PW = CW + COEF_W;

    logic signed [PW-1:0] p0_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    coef_t                t_reg;
    logic signed [SW-1:0] a_reg;
    logic signed [SW-1:0] b_reg;
    logic signed [SW-1:0] sum_reg;

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= PW'(x) * PW'(m0);
            p1_reg <= PW'(y) * PW'(m1);
            p2_reg <= PW'(z) * PW'(m2);
            t_reg  <= m3;
        end
    end

    // stage 2: pair sums, translation scaled by 1.0
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= SW'(p0_reg) + SW'(p1_reg);
            b_reg <= SW'(p2_reg) + (SW'(t_reg) <<< FB);
        end
    end

    // stage 3: column total
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= a_reg + b_reg;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== rtl/core/ptx_div_step.sv =====
// ptx_div_step: one registered restoring-division step, one quotient bit
// depends on ptx_pkg
module ptx_div_step
    import ptx_pkg::*;
#(
    parameter int SW = 66,
    parameter int QW = 33
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [SW-1:0] d,
    input  logic [SW-1:0] rem_in,
    input  logic [QW-1:0] low_in,
    input  logic [QW-1:0] q_in,
    output logic [SW-1:0] rem_out,
    output logic [QW-1:0] low_out,
    output logic [QW-1:0] q_out
);

    logic [SW-1:0] trial;
    logic          ge;
    logic [SW-1:0] rem_reg;
    logic [QW-1:0] low_reg;
    logic [QW-1:0] q_reg;

    // remainder stays below d, so the shift never loses a bit
    assign trial = {rem_in[SW-2:0], low_in[QW-1]};
    assign ge    = (trial >= d);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= ge ? (trial - d) : trial;
            low_reg <= {low_in[QW-2:0], 1'b0};
            q_reg   <= {q_in[QW-2:0], ge};
        end
    end

    assign rem_out = rem_reg;
    assign low_out = low_reg;
    assign q_out   = q_reg;

endmodule

// ===== rtl/core/point_transform_4x4.sv =====
// throughput: one word per cycle when not stalled; the divider is a chain of COORD_WIDTH + 1
//   restoring stages, one quotient bit per stage, shared by nothing
// stalls: the pipeline holds only when its last stage and the output register are both full and out_ready is low
// reset: rst_n async low clears valid bits; matrix goes to identity (1.0 = 1 << FRAC_BITS)
module point_transform_4x4
    import ptx_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_idx,
    input  cfg_word_t                     cfg_wdata,
    // input words
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_z,
    // output words
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic                          w_zero,
    output logic                          overflow
);

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = FRAC_BITS;
    // column sums are exact in SW bits
    localparam int SW  = ((CW > FB) ? CW : FB) + 34;
    // quotient bits kept; anything larger saturates
    localparam int QW  = CW + 1;
    // dividend is |S| << FB
    localparam int NW  = SW + FB;
    // dot stages, classify, divider setup, then the divider chain
    localparam int NST = 5 + QW;
    localparam int SIDE_W = 8 + 3 * CW + 1;

    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] CMAX = ~CMIN;
    localparam logic [QW-1:0] QHALF = QW'(1) << (CW - 1);
    localparam cfg_word_t     ONE_LO = CFG_DATA_W'(1) << FB;
    localparam cfg_word_t     ONE_HI = CFG_DATA_W'(1) << (FB + COEF_W);

    // ------------------------------------------------------------------
    // coefficient registers
    // ------------------------------------------------------------------
    cfg_word_t coef_reg [NUM_PAIRS];
    coef_t     m [4][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PAIRS; i++)
            begin
                coef_reg[i] <= '0;
            end
            coef_reg[REG_M00_M01] <= ONE_LO;
            coef_reg[REG_M10_M11] <= ONE_HI;
            coef_reg[REG_M22_M23] <= ONE_LO;
            coef_reg[REG_M32_M33] <= ONE_HI;
        end
        else if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_PAIRS)))
        begin
            // indexes past the register file are dropped
            coef_reg[cfg_idx[PAIR_IDX_W-1:0]] <= cfg_wdata;
        end
    end

    // m(r,c): low half holds the even column, high half the odd one
    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            if (c % 2 == 1)
            begin : g_hi
                assign m[r][c] = coef_reg[r * 2 + c / 2][CFG_DATA_W-1:COEF_W];
            end
            else
            begin : g_lo
                assign m[r][c] = coef_reg[r * 2 + c / 2][COEF_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // flow control: one shared advance, valid bits ride along
    // ------------------------------------------------------------------
    logic              en;
    logic [NST-1:0]    vld_reg;
    logic              out_valid_reg;
    logic              out_load;

    assign en       = !(vld_reg[NST-1] && out_valid_reg && !out_ready);
    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[NST-2:0], in_valid};
            end
            if (out_load)
            begin
                out_valid_reg <= vld_reg[NST-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 1-3: four column dot products
    // ------------------------------------------------------------------
    logic signed [SW-1:0] s [4];

    for (genvar c = 0; c < 4; c++)
    begin : g_dot
        ptx_dot #(
            .CW (CW),
            .FB (FB),
            .SW (SW)
        ) u_dot (
            .clk (clk),
            .en  (en),
            .x   (in_x),
            .y   (in_y),
            .z   (in_z),
            .m0  (m[0][c]),
            .m1  (m[1][c]),
            .m2  (m[2][c]),
            .m3  (m[3][c]),
            .sum (s[c])
        );
    end

    // ------------------------------------------------------------------
    // stage 4: classify w, magnitudes, and the w == 1.0 shortcut
    // ------------------------------------------------------------------
    logic [SW-1:0]    mag [4];
    logic [3:0]       sgn;
    logic [CW-1:0]    one_res [3];
    logic [2:0]       one_ov;

    logic [SW-1:0]    mag_reg [4];
    logic [3:0]       sgn_reg;
    logic             wzero_reg;
    logic             wone_reg;
    logic [CW-1:0]    one_res_reg [3];
    logic             one_ov_reg;

    always_comb
    begin
        logic signed [SW-1:0] sh;
        logic [SW-CW:0]       top;
        for (int c = 0; c < 4; c++)
        begin
            sgn[c] = s[c][SW-1];
            mag[c] = sgn[c] ? (~s[c] + SW'(1)) : s[c];
        end
        // floor shift, then clamp
        for (int c = 0; c < 3; c++)
        begin
            sh  = s[c] >>> FB;
            top = sh[SW-1:CW-1];
            if ((&top) || !(|top))
            begin
                one_res[c] = sh[CW-1:0];
                one_ov[c]  = 1'b0;
            end
            else
            begin
                one_res[c] = sgn[c] ? CMIN : CMAX;
                one_ov[c]  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mag_reg[c] <= mag[c];
            end
            for (int c = 0; c < 3; c++)
            begin
                one_res_reg[c] <= one_res[c];
            end
            sgn_reg    <= sgn;
            wzero_reg  <= (s[3] == '0);
            wone_reg   <= (s[3] == (SW'(1) << (2 * FB)));
            one_ov_reg <= |one_ov;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: divider setup; quotient too large for QW bits saturates
    // ------------------------------------------------------------------
    logic [SW-1:0]     rem0_reg [3];
    logic [QW-1:0]     low0_reg [3];
    logic [SW-1:0]     d0_reg;
    logic [SIDE_W-1:0] side0_reg;

    always_ff @(posedge clk)
    begin
        logic [NW-1:0] n;
        logic [NW-1:0] hi;
        logic [2:0]    big;
        logic [2:0]    neg;
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                n   = {mag_reg[c], {FB{1'b0}}};
                hi  = n >> QW;
                big[c] = (hi >= NW'(mag_reg[3]));
                neg[c] = sgn_reg[c] ^ sgn_reg[3];
                rem0_reg[c] <= hi[SW-1:0];
                low0_reg[c] <= n[QW-1:0];
            end
            d0_reg    <= mag_reg[3];
            side0_reg <= {wzero_reg, wone_reg, neg, big,
                          one_res_reg[0], one_res_reg[1], one_res_reg[2], one_ov_reg};
        end
    end

    // ------------------------------------------------------------------
    // stages 6 .. 5+QW: restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [SW-1:0]     rem_w  [QW][3];
    logic [QW-1:0]     low_w  [QW][3];
    logic [QW-1:0]     q_w    [QW][3];
    logic [SW-1:0]     d_reg  [QW];
    logic [SIDE_W-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [SW-1:0]     d_in;
        logic [SIDE_W-1:0] side_in;
        logic [SW-1:0]     rem_in [3];
        logic [QW-1:0]     low_in [3];
        logic [QW-1:0]     q_in   [3];

        if (k == 0)
        begin : g_first
            assign d_in    = d0_reg;
            assign side_in = side0_reg;
            for (genvar c = 0; c < 3; c++)
            begin : g_l
                assign rem_in[c] = rem0_reg[c];
                assign low_in[c] = low0_reg[c];
                assign q_in[c]   = '0;
            end
        end
        else
        begin : g_next
            assign d_in    = d_reg[k-1];
            assign side_in = side_reg[k-1];
            for (genvar c = 0; c < 3; c++)
            begin : g_l
                assign rem_in[c] = rem_w[k-1][c];
                assign low_in[c] = low_w[k-1][c];
                assign q_in[c]   = q_w[k-1][c];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k]    <= d_in;
                side_reg[k] <= side_in;
            end
        end

        for (genvar c = 0; c < 3; c++)
        begin : g_lane
            ptx_div_step #(
                .SW (SW),
                .QW (QW)
            ) u_step (
                .clk     (clk),
                .en      (en),
                .d       (d_in),
                .rem_in  (rem_in[c]),
                .low_in  (low_in[c]),
                .q_in    (q_in[c]),
                .rem_out (rem_w[k][c]),
                .low_out (low_w[k][c]),
                .q_out   (q_w[k][c])
            );
        end
    end

    // ------------------------------------------------------------------
    // output register: sign, clamp, pick the path
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] side_last;
    logic              f_wzero;
    logic              f_wone;
    logic [2:0]        f_neg;
    logic [2:0]        f_big;
    logic [CW-1:0]     f_one [3];
    logic              f_one_ov;
    logic [CW-1:0]     div_res [3];
    logic [2:0]        div_ov;
    logic [CW-1:0]     res [3];
    logic              res_ov;

    assign side_last = side_reg[QW-1];
    assign {f_wzero, f_wone, f_neg, f_big, f_one[0], f_one[1], f_one[2], f_one_ov} = side_last;

    always_comb
    begin
        logic [QW-1:0] q;
        logic [QW-1:0] qn;
        for (int c = 0; c < 3; c++)
        begin
            q  = q_w[QW-1][c];
            qn = ~q + QW'(1);
            div_ov[c]  = 1'b0;
            div_res[c] = q[CW-1:0];
            if (f_big[c])
            begin
                div_ov[c]  = 1'b1;
                div_res[c] = f_neg[c] ? CMIN : CMAX;
            end
            else if (f_neg[c])
            begin
                if (q > QHALF)
                begin
                    div_ov[c]  = 1'b1;
                    div_res[c] = CMIN;
                end
                else
                begin
                    div_res[c] = qn[CW-1:0];
                end
            end
            else if (q > (QHALF - QW'(1)))
            begin
                div_ov[c]  = 1'b1;
                div_res[c] = CMAX;
            end
        end

        if (f_wzero)
        begin
            for (int c = 0; c < 3; c++)
            begin
                res[c] = '0;
            end
            res_ov = 1'b0;
        end
        else if (f_wone)
        begin
            for (int c = 0; c < 3; c++)
            begin
                res[c] = f_one[c];
            end
            res_ov = f_one_ov;
        end
        else
        begin
            for (int c = 0; c < 3; c++)
            begin
                res[c] = div_res[c];
            end
            res_ov = |div_ov;
        end
    end

    logic [CW-1:0] out_x_reg;
    logic [CW-1:0] out_y_reg;
    logic [CW-1:0] out_z_reg;
    logic          w_zero_reg;
    logic          overflow_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg    <= res[0];
            out_y_reg    <= res[1];
            out_z_reg    <= res[2];
            w_zero_reg   <= f_wzero;
            overflow_reg <= res_ov;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign w_zero    = w_zero_reg;
    assign overflow  = overflow_reg;

endmodule

// ===== rtl/core/ptx_checker.sv =====
// ptx_checker: port-level assertions for point_transform_4x4, bound to the top level
// depends on point_transform_4x4 ports only
module ptx_checker #(
    parameter int CW = 32
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [CW-1:0] out_x,
    input logic [CW-1:0] out_y,
    input logic [CW-1:0] out_z,
    input logic          w_zero,
    input logic          overflow
);

    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] CMAX = ~CMIN;

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(w_zero) && $stable(overflow))
        else $error("output word changed while stalled");

    // empty output never blocks the input
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // zero w gives zero coordinates and no overflow
    a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && w_zero |-> out_x == '0 && out_y == '0 && out_z == '0 && !overflow)
        else $error("w_zero word with nonzero payload");

    // overflow means some coordinate sits at a rail
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> out_x == CMIN || out_x == CMAX || out_y == CMIN
            || out_y == CMAX || out_z == CMIN || out_z == CMAX)
        else $error("overflow without a saturated coordinate");

endmodule

bind point_transform_4x4 ptx_checker #(
    .CW (COORD_WIDTH)
) u_ptx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .w_zero    (w_zero),
    .overflow  (overflow)
);

// ===== tb/tb.sv =====
// tb: self-checking testbench for point_transform_4x4
// depends on ptx_pkg and the point_transform_4x4 rtl; nothing else
module tb;
    import ptx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = 32;
    localparam int FB        = 16;
    localparam int TAIL_WAIT = 60;     // longer than the pipeline latency
    localparam int WDOG_MAX  = 3000;   // cycles with no word moving on either side
    localparam logic signed [CW-1:0] ONE  = 32'sd65536;
    localparam logic signed [CW-1:0] CMAX = 32'sh7fffffff;
    localparam logic signed [CW-1:0] CMIN = 32'sh80000000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 wz;
        logic                 ov;
    } point_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    cfg_word_t cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic signed [CW-1:0] in_x, in_y, in_z;
    logic out_valid;
    logic out_ready;
    logic signed [CW-1:0] out_x, out_y, out_z;
    logic w_zero;
    logic overflow;

    // testbench copy of the matrix, m[row][col]
    coef_t mat [4][4];
    point_res_t pending_points [$];
    int error_count;
    int idle_cycles;
    // knobs owned by the test sequence
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;

    point_transform_4x4 #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .w_zero    (w_zero),
        .overflow  (overflow)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // clamp a wide value to the coordinate range, flag if clamped
    function automatic logic signed [CW-1:0] clamp_coord(input logic signed [127:0] v,
                                                         inout logic ov);
        if (v > 128'(CMAX))
        begin
            ov = 1'b1;
            return CMAX;
        end
        if (v < 128'(CMIN))
        begin
            ov = 1'b1;
            return CMIN;
        end
        return v[CW-1:0];
    endfunction

    // row vector (x, y, z, 1) times the matrix, then the homogeneous divide
    function automatic point_res_t transform_point(input logic signed [CW-1:0] px,
                                                   input logic signed [CW-1:0] py,
                                                   input logic signed [CW-1:0] pz);
        logic signed [127:0] p [4];
        logic signed [127:0] s [4];
        logic signed [127:0] cm;
        logic [127:0] nm;
        logic [127:0] wm;
        logic [127:0] q;
        logic signed [CW-1:0] res [3];
        logic ov;
        point_res_t r;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        p[3] = 128'sd1 <<< FB;
        ov = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            s[c] = '0;
            for (int k = 0; k < 4; k++)
            begin
                cm = mat[k][c];
                s[c] = s[c] + p[k] * cm;
            end
        end
        r = '0;
        if (s[3] == 0)
        begin
            r.wz = 1'b1;
            return r;
        end
        for (int c = 0; c < 3; c++)
        begin
            if (s[3] == (128'sd1 <<< (2 * FB)))
            begin
                // unit w: plain floor shift
                res[c] = clamp_coord(s[c] >>> FB, ov);
            end
            else
            begin
                // divide magnitudes, truncate toward zero
                nm = (s[c] < 0 ? -s[c] : s[c]) << FB;
                wm = s[3] < 0 ? -s[3] : s[3];
                q = nm / wm;
                if ((s[c] < 0) != (s[3] < 0))
                    q = -q;
                res[c] = clamp_coord($signed(q), ov);
            end
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        r.ov = ov;
        return r;
    endfunction

    function automatic int pick_gap(input int pct);
        int roll;
        roll = $urandom_range(99);
        if (roll >= pct)
            return 0;
        if (roll < pct / 8)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // coefficient or coordinate mix: small values, plus extremes and full random when allow_huge is set
    function automatic logic signed [CW-1:0] pick_value(input bit allow_huge);
        case ($urandom_range(9))
            0: return '0;
            1: return ONE;
            2: return -ONE;
            3: return allow_huge ? CMAX : ONE;
            4: return allow_huge ? CMIN : -ONE;
            5, 6: return allow_huge ? $urandom : $signed($urandom_range(65535)) - 32768;
            default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    // writes all eight pairs; extra writes go to unused indexes and are dropped
    task automatic load_matrix(input coef_t m [4][4], input bit with_junk);
        int last;
        last = with_junk ? 15 : 7;
        for (int i = 0; i <= last; i++)
        begin
            cfg_we <= 1'b1;
            cfg_idx <= i[CFG_IDX_W-1:0];
            if (i < NUM_PAIRS)
            begin
                cfg_wdata <= {m[i / 2][(i % 2) * 2 + 1], m[i / 2][(i % 2) * 2]};
                mat[i / 2][(i % 2) * 2] = m[i / 2][(i % 2) * 2];
                mat[i / 2][(i % 2) * 2 + 1] = m[i / 2][(i % 2) * 2 + 1];
            end
            else
            begin
                cfg_wdata <= {$urandom, $urandom};
            end
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // stop offering, wait for all results plus pipeline flush before touching registers
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    // offers one point, waits for acceptance, records the expected word
    task automatic send_point(input logic signed [CW-1:0] px,
                              input logic signed [CW-1:0] py,
                              input logic signed [CW-1:0] pz);
        bit hit;
        int gap;
        in_valid <= 1'b1;
        in_x <= px;
        in_y <= py;
        in_z <= pz;
        do
        begin
            @(negedge clk);
            hit = in_ready;
            @(posedge clk);
        end
        while (!hit);
        pending_points.push_back(transform_point(px, py, pz));
        gap = pick_gap(send_idle_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic void identity_matrix(output coef_t m [4][4]);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = (r == c) ? ONE : '0;
    endfunction

    task automatic send_random_points(input int count, input bit huge);
        for (int i = 0; i < count; i++)
            send_point(pick_value(huge), pick_value(huge), pick_value(huge));
    endtask

    // reset matrix is identity: coordinate extremes pass straight through
    task automatic test_reset_identity();
        send_point('0, '0, '0);
        send_point(CMAX, CMIN, -1);
        send_point(CMIN, CMAX, 1);
        send_point(ONE, -ONE, 32'sh0001_8000);
        send_point(32'sh5555_aaaa, 32'shaaaa_5555, 32'sh0f0f_f0f0);
    endtask

    task automatic test_directed_cases();
        coef_t m [4][4];
        // translation that saturates, floor rounding on the unit-w path
        identity_matrix(m);
        m[3][0] = CMAX;
        m[3][1] = CMIN;
        m[3][2] = -1;
        m[0][0] = 32'sh0000_8000;
        drain_pipeline();
        load_matrix(m, 1'b1);
        send_point(CMAX, CMIN, '0);
        send_point(-1, 1, 3);
        send_point(CMIN, CMAX, -3);
        // zero w
        identity_matrix(m);
        m[3][3] = '0;
        drain_pipeline();
        load_matrix(m, 1'b0);
        send_point(ONE, ONE, ONE);
        send_point(CMAX, CMIN, CMAX);
        // tiny w: quotient blows up and clamps
        m[3][3] = 1;
        drain_pipeline();
        load_matrix(m, 1'b0);
        send_point(ONE, -ONE, '0);
        send_point(3, -7, 1);
        // negative w and perspective column, divide path rounds toward zero
        identity_matrix(m);
        m[3][3] = -ONE;
        m[2][3] = 32'sh0000_4000;
        m[0][1] = 32'sh0000_3333;
        drain_pipeline();
        load_matrix(m, 1'b0);
        send_point(ONE, 32'sh0002_0000, 32'sh0004_0000);
        send_point(-5, 7, -11);
        send_point(CMIN, CMIN, CMIN);
        // every coefficient at its extremes
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = ((r + c) % 2) ? CMIN : CMAX;
        drain_pipeline();
        load_matrix(m, 1'b0);
        send_point(CMAX, CMIN, CMAX);
        send_point(CMIN, CMIN, CMIN);
        send_point(1, 0, -1);
    endtask

    // phases of random matrices, mostly affine so the unit-w path gets traffic
    task automatic test_random_matrices();
        coef_t m [4][4];
        bit huge;
        for (int ph = 0; ph < 24; ph++)
        begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    m[r][c] = pick_value(1'b1);
            if ($urandom_range(2) != 0)
            begin
                m[0][3] = '0;
                m[1][3] = '0;
                m[2][3] = '0;
                m[3][3] = ONE;
            end
            send_idle_pct = (ph % 4 == 0) ? 0 : $urandom_range(60, 10);
            recv_idle_pct = (ph % 4 == 1) ? 0 : $urandom_range(60, 10);
            huge = (ph % 3 == 0);
            drain_pipeline();
            load_matrix(m, ph % 5 == 0);
            send_random_points(60, huge);
        end
    endtask

    // receiver holds off while points keep coming, filling the pipeline
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 20;
        hold_req = hold_req + 1;
        send_random_points(120, 1'b1);
    endtask

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin : recv_ready
        int hold_left;
        int hold_seen;
        int gap_left;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
            gap_left = 0;
        end
        else
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                gap_left = pick_gap(recv_idle_pct);
                out_ready <= (gap_left == 0);
            end
        end
    end

    // outputs are stable at the falling edge; the word moves at the next rise
    always @(negedge clk)
    begin : check_output
        point_res_t exp_pt;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: output word with nothing expected x=%h y=%h z=%h",
                         $time, out_x, out_y, out_z);
                error_count++;
            end
            else
            begin
                exp_pt = pending_points.pop_front();
                if (exp_pt.x !== out_x || exp_pt.y !== out_y || exp_pt.z !== out_z
                    || exp_pt.wz !== w_zero || exp_pt.ov !== overflow)
                begin
                    $display("%0t: mismatch expected x=%h y=%h z=%h wz=%b ov=%b",
                             $time, exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.wz, exp_pt.ov);
                    $display("%0t:          actual   x=%h y=%h z=%h wz=%b ov=%b",
                             $time, out_x, out_y, out_z, w_zero, overflow);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles where no word moves on either side
    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("[point_transform_4x4] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_x = '0;
        in_y = '0;
        in_z = '0;
        error_count = 0;
        idle_cycles = 0;
        hold_req = 0;
        send_idle_pct = 30;
        recv_idle_pct = 30;
        identity_matrix(mat);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        test_reset_identity();
        test_directed_cases();
        test_backpressure();
        test_random_matrices();
        test_backpressure();

        drain_pipeline();
        if (error_count == 0)
            $display("[point_transform_4x4] OK");
        else
            $display("[point_transform_4x4] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ptx_pkg.sv
rtl/core/ptx_dot.sv
rtl/core/ptx_div_step.sv
rtl/core/point_transform_4x4.sv
rtl/core/ptx_checker.sv
tb/tb.sv
